// ----- rtl/text_console_cursor_scroll_macros.svh -----
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH

// same-cycle implication
`define TCCS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text_console_cursor_scroll: check failed");

// next-cycle implication
`define TCCS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text_console_cursor_scroll: check failed");

`endif

// ----- rtl/tccs_pkg.sv -----
package tccs_pkg;

  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int DATA_W     = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  localparam int MAX_COLS_DEF  = 128;
  localparam int MAX_ROWS_DEF  = 32;
  localparam int TAB_WIDTH_DEF = 4;
  localparam int COLS_RESET    = 80;
  localparam int ROWS_RESET    = 25;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POKE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [DATA_W-1:0] CELL_ATTR = 16'h0F00;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 4'd1;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_TAB,
    OP_NEWLINE,
    OP_RETURN,
    OP_POKE,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } tccs_op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PRE,
    ST_ACT,
    ST_SCROLL,
    ST_CLEAR,
    ST_RDWAIT,
    ST_EMIT
  } tccs_state_e;

  typedef struct packed {
    tccs_op_e          kind;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
  } tccs_op_t;

endpackage

// ----- rtl/tccs_if.sv -----
interface tccs_in_if;
  logic                           valid;
  logic                           ready;
  logic [tccs_pkg::CMD_W-1:0]     cmd;
  logic [tccs_pkg::CHAR_W-1:0]    char_code;
  logic [tccs_pkg::COL_W-1:0]     column;
  logic [tccs_pkg::ROW_W-1:0]     row;

  modport source (output valid, cmd, char_code, column, row, input ready);
  modport sink   (input valid, cmd, char_code, column, row, output ready);
endinterface

interface tccs_out_if;
  logic                           valid;
  logic                           ready;
  logic [tccs_pkg::DATA_W-1:0]    cell_data;
  logic [tccs_pkg::COL_W-1:0]     cursor_column;
  logic [tccs_pkg::ROW_W-1:0]     cursor_row;

  modport source (output valid, cell_data, cursor_column, cursor_row, input ready);
  modport sink   (input valid, cell_data, cursor_column, cursor_row, output ready);
endinterface

interface tccs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tccs_pkg::CFG_IDX_W-1:0]   index;
  logic [tccs_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/text_console_cursor_scroll.sv -----
// Text-mode console with a cursor and scrolling. Commands enter on in_bus and are decoded
// into a two-entry queue; a sequencer drains the queue and drives the cell RAM
// (MAX_COLS * MAX_ROWS cells of 16 bits, one write and one read port) and returns one
// result beat per command on out_bus. During a scroll every cell of the shifted rows
// passes through the single RAM write port once. After reset the store is zeroed,
// during which in_bus.ready stays low; configuration writes are taken at all times
// and must only be issued while the console is idle.
`include "text_console_cursor_scroll_macros.svh"

module text_console_cursor_scroll #(
  parameter int MAX_COLS  = tccs_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS  = tccs_pkg::MAX_ROWS_DEF,
  parameter int TAB_WIDTH = tccs_pkg::TAB_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tccs_in_if.sink     in_bus,
  tccs_cfg_if.sink    cfg_bus,
  tccs_out_if.source  out_bus
);

  localparam int ECW = $clog2(MAX_COLS + 1);
  localparam int ERW = $clog2(MAX_ROWS + 1);

  logic               init_busy;
  logic               q_full;
  logic               q_empty;
  logic               push;
  logic               pop;
  tccs_pkg::tccs_op_t push_op;
  tccs_pkg::tccs_op_t head_op;
  logic [ECW-1:0]     eff_cols;
  logic [ERW-1:0]     eff_rows;

  tccs_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_bus      (in_bus),
    .cfg_bus     (cfg_bus),
    .init_busy_i (init_busy),
    .q_full_i    (q_full),
    .push_o      (push),
    .op_o        (push_op),
    .eff_cols_o  (eff_cols),
    .eff_rows_o  (eff_rows)
  );

  tccs_fifo #(
    .DEPTH (tccs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_op),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (head_op),
    .empty_o (q_empty)
  );

  tccs_back #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eff_cols_i  (eff_cols),
    .eff_rows_i  (eff_rows),
    .op_valid_i  (!q_empty),
    .op_i        (head_op),
    .op_pop_o    (pop),
    .init_busy_o (init_busy),
    .out_bus     (out_bus)
  );

  `TCCS_ASSERT_IMP(a_init_blocks_in, clk_i, rst_ni, init_busy, !in_bus.ready)
  `TCCS_ASSERT_IMP(a_full_blocks_in, clk_i, rst_ni, q_full, !in_bus.ready)
  `TCCS_ASSERT_IMP(a_init_no_result, clk_i, rst_ni, init_busy, !out_bus.valid)
  `TCCS_ASSERT_NXT(a_accept_queued, clk_i, rst_ni, in_bus.valid && in_bus.ready, !q_empty)

endmodule

// ----- rtl/tccs_ram.sv -----
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tccs_fifo.sv -----
module tccs_fifo #(
  parameter int DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tccs_pkg::tccs_op_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output tccs_pkg::tccs_op_t data_o,
  output logic               empty_o
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  tccs_pkg::tccs_op_t mem_q [DEPTH];
  logic [PW-1:0]      wptr_q, wptr_d;
  logic [PW-1:0]      rptr_q, rptr_d;
  logic [CNTW-1:0]    cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNTW'(DEPTH));

endmodule

// ----- rtl/tccs_front.sv -----
module tccs_front #(
  parameter int MAX_COLS = tccs_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tccs_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tccs_in_if.sink                         in_bus,
  tccs_cfg_if.sink                        cfg_bus,
  input  logic                            init_busy_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output tccs_pkg::tccs_op_t              op_o,
  output logic [$clog2(MAX_COLS + 1)-1:0] eff_cols_o,
  output logic [$clog2(MAX_ROWS + 1)-1:0] eff_rows_o
);

  localparam int ECW      = $clog2(MAX_COLS + 1);
  localparam int ERW      = $clog2(MAX_ROWS + 1);
  localparam int COLS_RST = (tccs_pkg::COLS_RESET > MAX_COLS) ? MAX_COLS : tccs_pkg::COLS_RESET;
  localparam int ROWS_RST = (tccs_pkg::ROWS_RESET > MAX_ROWS) ? MAX_ROWS : tccs_pkg::ROWS_RESET;

  logic [ECW-1:0] cols_q, cols_d;
  logic [ERW-1:0] rows_q, rows_d;
  logic           cfg_we;
  logic           on_screen;

  function automatic logic [31:0] clamp(input logic [31:0] v, input logic [31:0] hi);
    if (v == 32'd0) begin
      return 32'd1;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  assign cfg_bus.ready = 1'b1;
  assign cfg_we        = cfg_bus.valid && cfg_bus.ready;

  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    if (cfg_we) begin
      case (cfg_bus.index)
        tccs_pkg::REG_COLUMNS: cols_d = ECW'(clamp(32'(cfg_bus.data), 32'(MAX_COLS)));
        tccs_pkg::REG_ROWS:    rows_d = ERW'(clamp(32'(cfg_bus.data[5:0]), 32'(MAX_ROWS)));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= ECW'(COLS_RST);
      rows_q <= ERW'(ROWS_RST);
    end else begin
      cols_q <= cols_d;
      rows_q <= rows_d;
    end
  end

  assign on_screen = (32'(in_bus.column) < 32'(cols_q)) && (32'(in_bus.row) < 32'(rows_q));

  always_comb begin
    op_o.char_code = in_bus.char_code;
    op_o.column    = in_bus.column;
    op_o.row       = in_bus.row;
    op_o.kind      = tccs_pkg::OP_NOP;
    unique case (in_bus.cmd)
      tccs_pkg::CMD_PUT: begin
        case (in_bus.char_code)
          tccs_pkg::CH_TAB: op_o.kind = tccs_pkg::OP_TAB;
          tccs_pkg::CH_LF:  op_o.kind = tccs_pkg::OP_NEWLINE;
          tccs_pkg::CH_CR:  op_o.kind = tccs_pkg::OP_RETURN;
          default:          op_o.kind = tccs_pkg::OP_PUT;
        endcase
      end
      tccs_pkg::CMD_POKE:  op_o.kind = on_screen ? tccs_pkg::OP_POKE : tccs_pkg::OP_NOP;
      tccs_pkg::CMD_CLEAR: op_o.kind = tccs_pkg::OP_CLEAR;
      tccs_pkg::CMD_READ:  op_o.kind = on_screen ? tccs_pkg::OP_READ : tccs_pkg::OP_NOP;
    endcase
  end

  assign in_bus.ready = !q_full_i && !init_busy_i;
  assign push_o       = in_bus.valid && in_bus.ready;
  assign eff_cols_o   = cols_q;
  assign eff_rows_o   = rows_q;

endmodule

// ----- rtl/tccs_back.sv -----
module tccs_back #(
  parameter int MAX_COLS  = tccs_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS  = tccs_pkg::MAX_ROWS_DEF,
  parameter int TAB_WIDTH = tccs_pkg::TAB_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [$clog2(MAX_COLS + 1)-1:0] eff_cols_i,
  input  logic [$clog2(MAX_ROWS + 1)-1:0] eff_rows_i,
  input  logic                            op_valid_i,
  input  tccs_pkg::tccs_op_t              op_i,
  output logic                            op_pop_o,
  output logic                            init_busy_o,
  tccs_out_if.source                      out_bus
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = AW + 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int TCW   = $clog2(TAB_WIDTH + 1);
  localparam int DW    = tccs_pkg::DATA_W;

  tccs_pkg::tccs_state_e     state_q, state_d;
  tccs_pkg::tccs_state_e     ret_q, ret_d;
  tccs_pkg::tccs_state_e     nxt;
  tccs_pkg::tccs_op_e        kind_q, kind_d;
  logic [tccs_pkg::CHAR_W-1:0] char_q, char_d;
  logic [TCW-1:0]            count_q, count_d;
  logic [CW-1:0]             col_q, col_d;
  logic [RW-1:0]             row_q, row_d;
  logic [DW-1:0]             data_q, data_d;
  logic [PW-1:0]             ptr_q, ptr_d;
  logic [AW-1:0]             wr_ptr_q, wr_ptr_d;
  logic                      rd_pend_q, rd_pend_d;
  logic [PW-1:0]             copy_end_q, copy_end_d;
  logic [PW-1:0]             zero_end_q, zero_end_d;
  logic                      out_valid_q, out_valid_d;
  logic [DW-1:0]             out_data_q, out_data_d;
  logic [CW-1:0]             out_col_q, out_col_d;
  logic [RW-1:0]             out_row_q, out_row_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  logic          start_scroll;
  logic          wrap;
  logic [31:0]   ec_w, er_w, col_n, row_n;
  logic [31:0]   out_col_w, out_row_w;

  function automatic logic [AW-1:0] cell_addr(input logic [31:0] r, input logic [31:0] c);
    logic [31:0] a;
    a = r * MAX_COLS + c;
    return a[AW-1:0];
  endfunction

  tccs_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ec_w = 32'(eff_cols_i);
  assign er_w = 32'(eff_rows_i);

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    kind_d       = kind_q;
    char_d       = char_q;
    count_d      = count_q;
    col_d        = col_q;
    row_d        = row_q;
    data_d       = data_q;
    ptr_d        = ptr_q;
    wr_ptr_d     = wr_ptr_q;
    rd_pend_d    = rd_pend_q;
    copy_end_d   = copy_end_q;
    zero_end_d   = zero_end_q;
    out_valid_d  = out_valid_q && !out_bus.ready;
    out_data_d   = out_data_q;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    op_pop_o     = 1'b0;
    start_scroll = 1'b0;
    wrap         = 1'b0;
    nxt          = tccs_pkg::ST_EMIT;
    col_n        = 32'(col_q) + 32'd1;
    row_n        = 32'(row_q) + 32'd1;

    unique case (state_q) inside
      tccs_pkg::ST_INIT, tccs_pkg::ST_CLEAR: begin
        if (32'(ptr_q) < DEPTH) begin
          ram_we    = 1'b1;
          ram_waddr = ptr_q[AW-1:0];
          ptr_d     = ptr_q + 1'b1;
        end else begin
          state_d = (state_q == tccs_pkg::ST_INIT) ? tccs_pkg::ST_IDLE : tccs_pkg::ST_EMIT;
        end
      end

      tccs_pkg::ST_IDLE: begin
        if (op_valid_i) begin
          op_pop_o = 1'b1;
          kind_d   = op_i.kind;
          char_d   = op_i.char_code;
          count_d  = TCW'(1);
          data_d   = '0;
          unique case (op_i.kind) inside
            tccs_pkg::OP_TAB: begin
              char_d  = tccs_pkg::CH_SPACE;
              count_d = TCW'(TAB_WIDTH);
              state_d = tccs_pkg::ST_PRE;
            end
            tccs_pkg::OP_PUT, tccs_pkg::OP_NEWLINE, tccs_pkg::OP_RETURN: begin
              state_d = tccs_pkg::ST_PRE;
            end
            tccs_pkg::OP_POKE: begin
              ram_we    = 1'b1;
              ram_waddr = cell_addr(32'(op_i.row), 32'(op_i.column));
              ram_wdata = tccs_pkg::CELL_ATTR | DW'(op_i.char_code);
              state_d   = tccs_pkg::ST_EMIT;
            end
            tccs_pkg::OP_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              ptr_d   = '0;
              state_d = tccs_pkg::ST_CLEAR;
            end
            tccs_pkg::OP_READ: begin
              ram_re    = 1'b1;
              ram_raddr = cell_addr(32'(op_i.row), 32'(op_i.column));
              state_d   = tccs_pkg::ST_RDWAIT;
            end
            default: state_d = tccs_pkg::ST_EMIT;
          endcase
        end
      end

      tccs_pkg::ST_PRE: begin
        wrap  = (32'(col_q) >= ec_w);
        row_n = 32'(row_q) + (wrap ? 32'd1 : 32'd0);
        if (row_n >= er_w) begin
          start_scroll = 1'b1;
          ret_d        = tccs_pkg::ST_ACT;
        end else begin
          col_d   = wrap ? '0 : col_q;
          row_d   = RW'(row_n);
          state_d = tccs_pkg::ST_ACT;
        end
      end

      tccs_pkg::ST_ACT: begin
        unique case (kind_q) inside
          tccs_pkg::OP_PUT, tccs_pkg::OP_TAB: begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(32'(row_q), 32'(col_q));
            ram_wdata = tccs_pkg::CELL_ATTR | DW'(char_q);
            count_d   = count_q - 1'b1;
            nxt       = (count_q == TCW'(1)) ? tccs_pkg::ST_EMIT : tccs_pkg::ST_ACT;
            if (col_n >= ec_w) begin
              if (row_n >= er_w) begin
                start_scroll = 1'b1;
                ret_d        = nxt;
              end else begin
                col_d   = '0;
                row_d   = RW'(row_n);
                state_d = nxt;
              end
            end else begin
              col_d   = CW'(col_n);
              state_d = nxt;
            end
          end
          tccs_pkg::OP_NEWLINE: begin
            if (row_n >= er_w) begin
              start_scroll = 1'b1;
              ret_d        = tccs_pkg::ST_EMIT;
            end else begin
              col_d   = '0;
              row_d   = RW'(row_n);
              state_d = tccs_pkg::ST_EMIT;
            end
          end
          tccs_pkg::OP_RETURN: begin
            col_d   = '0;
            state_d = tccs_pkg::ST_EMIT;
          end
          default: state_d = tccs_pkg::ST_EMIT;
        endcase
      end

      tccs_pkg::ST_SCROLL: begin
        if (rd_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_ptr_q;
          ram_wdata = ram_rdata;
        end
        if (ptr_q < copy_end_q) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(32'(ptr_q) + 32'(MAX_COLS));
          wr_ptr_d  = ptr_q[AW-1:0];
          rd_pend_d = 1'b1;
          ptr_d     = ptr_q + 1'b1;
        end else begin
          rd_pend_d = 1'b0;
          if (!rd_pend_q) begin
            if (ptr_q < zero_end_q) begin
              ram_we    = 1'b1;
              ram_waddr = ptr_q[AW-1:0];
              ram_wdata = '0;
              ptr_d     = ptr_q + 1'b1;
            end else begin
              state_d = ret_q;
            end
          end
        end
      end

      tccs_pkg::ST_RDWAIT: begin
        data_d  = ram_rdata;
        state_d = tccs_pkg::ST_EMIT;
      end

      tccs_pkg::ST_EMIT: begin
        if (!out_valid_q || out_bus.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = data_q;
          out_col_d   = col_q;
          out_row_d   = row_q;
          state_d     = tccs_pkg::ST_IDLE;
        end
      end
    endcase

    if (start_scroll) begin
      ptr_d      = '0;
      rd_pend_d  = 1'b0;
      copy_end_d = PW'((er_w - 32'd1) * MAX_COLS);
      zero_end_d = PW'(er_w * MAX_COLS);
      col_d      = '0;
      row_d      = RW'(er_w - 32'd1);
      state_d    = tccs_pkg::ST_SCROLL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tccs_pkg::ST_INIT;
      ret_q       <= tccs_pkg::ST_IDLE;
      kind_q      <= tccs_pkg::OP_NOP;
      count_q     <= '0;
      col_q       <= '0;
      row_q       <= '0;
      ptr_q       <= '0;
      rd_pend_q   <= 1'b0;
      copy_end_q  <= '0;
      zero_end_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      kind_q      <= kind_d;
      count_q     <= count_d;
      col_q       <= col_d;
      row_q       <= row_d;
      ptr_q       <= ptr_d;
      rd_pend_q   <= rd_pend_d;
      copy_end_q  <= copy_end_d;
      zero_end_q  <= zero_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    data_q     <= data_d;
    wr_ptr_q   <= wr_ptr_d;
    out_data_q <= out_data_d;
    out_col_q  <= out_col_d;
    out_row_q  <= out_row_d;
  end

  assign out_col_w = 32'(out_col_q);
  assign out_row_w = 32'(out_row_q);

  assign init_busy_o           = (state_q == tccs_pkg::ST_INIT);
  assign out_bus.valid         = out_valid_q;
  assign out_bus.cell_data     = out_data_q;
  assign out_bus.cursor_column = out_col_w[tccs_pkg::COL_W-1:0];
  assign out_bus.cursor_row    = out_row_w[tccs_pkg::ROW_W-1:0];

endmodule
